[rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Field widths, function codes, register map and the structs passed between
// the configuration block, the sequencer and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

    // Payload widths
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int TILE_W   = 16;
    localparam int LEFT_W   = 16;
    localparam int TOP_W    = 24;
    localparam int RIGHT_W  = 17;
    localparam int BOTTOM_W = 25;

    // Register widths
    localparam int COLS_W  = 9;
    localparam int DIM_W   = 9;
    localparam int DELAY_W = 8;
    localparam int COUNT_W = 7;

    // APB
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Default table depth
    localparam int DEF_MAX_FRAMES = 64;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DRAW    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REFRESH = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIRST_TILE_ID = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_DELAY   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd5;

    // Register reset values
    localparam logic [TILE_W-1:0]  RST_FIRST_TILE_ID = 16'd1;
    localparam logic [COLS_W-1:0]  RST_SHEET_COLUMNS = 9'd1;
    localparam logic [DIM_W-1:0]   RST_TILE_WIDTH    = 9'd16;
    localparam logic [DIM_W-1:0]   RST_TILE_HEIGHT   = 9'd16;
    localparam logic [DELAY_W-1:0] RST_FRAME_DELAY   = 8'd0;
    localparam logic [COUNT_W-1:0] RST_FRAME_COUNT   = 7'd1;

    typedef struct packed {
        logic [TILE_W-1:0]  first_tile_id;
        logic [COLS_W-1:0]  sheet_columns;
        logic [DIM_W-1:0]   tile_width;
        logic [DIM_W-1:0]   tile_height;
        logic [DELAY_W-1:0] frame_delay;
        logic [COUNT_W-1:0] frame_count;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [TILE_W-1:0] dividend;
        logic [COLS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TILE_W-1:0] quotient;
        logic [COLS_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/sfs_in_if.sv]
// ----------------------------------------------------------------------------
// sfs_in_if: command channel of the sprite frame sequencer
// Valid/ready channel carrying one load, draw or refresh command.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_in_if import sfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] entry_index;
    logic [TILE_W-1:0]  entry_tile_id;

    modport source (output valid, func, entry_index, entry_tile_id, input ready);
    modport sink   (input valid, func, entry_index, entry_tile_id, output ready);
endinterface

`default_nettype wire

[rtl/sfs_out_if.sv]
// ----------------------------------------------------------------------------
// sfs_out_if: rectangle channel of the sprite frame sequencer
// Valid/ready channel carrying one source tile rectangle per draw.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_out_if import sfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LEFT_W-1:0]   rect_left;
    logic [TOP_W-1:0]    rect_top;
    logic [RIGHT_W-1:0]  rect_right;
    logic [BOTTOM_W-1:0] rect_bottom;
    logic                invalid;

    modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, invalid,
                    input ready);
    modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom, invalid,
                    output ready);
endinterface

`default_nettype wire

[rtl/sfs_cfg.sv]
// ----------------------------------------------------------------------------
// sfs_cfg: configuration registers
// APB-style register file holding sheet geometry and animation timing.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_cfg import sfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_tile_id <= RST_FIRST_TILE_ID;
            r_cfg.sheet_columns <= RST_SHEET_COLUMNS;
            r_cfg.tile_width    <= RST_TILE_WIDTH;
            r_cfg.tile_height   <= RST_TILE_HEIGHT;
            r_cfg.frame_delay   <= RST_FRAME_DELAY;
            r_cfg.frame_count   <= RST_FRAME_COUNT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FIRST_TILE_ID: r_cfg.first_tile_id <= pwdata[TILE_W-1:0];
                REG_SHEET_COLUMNS: r_cfg.sheet_columns <= pwdata[COLS_W-1:0];
                REG_TILE_WIDTH:    r_cfg.tile_width    <= pwdata[DIM_W-1:0];
                REG_TILE_HEIGHT:   r_cfg.tile_height   <= pwdata[DIM_W-1:0];
                REG_FRAME_DELAY:   r_cfg.frame_delay   <= pwdata[DELAY_W-1:0];
                REG_FRAME_COUNT:   r_cfg.frame_count   <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FIRST_TILE_ID: prdata = APB_DATA_W'(r_cfg.first_tile_id);
            REG_SHEET_COLUMNS: prdata = APB_DATA_W'(r_cfg.sheet_columns);
            REG_TILE_WIDTH:    prdata = APB_DATA_W'(r_cfg.tile_width);
            REG_TILE_HEIGHT:   prdata = APB_DATA_W'(r_cfg.tile_height);
            REG_FRAME_DELAY:   prdata = APB_DATA_W'(r_cfg.frame_delay);
            REG_FRAME_COUNT:   prdata = APB_DATA_W'(r_cfg.frame_count);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/sfs_div.sv]
// ----------------------------------------------------------------------------
// sfs_div: iterative divider
// Restoring division of the relative tile id by the column count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_div import sfs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int STEP_W = $clog2(TILE_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [TILE_W-1:0]   r_quo;
    logic [COLS_W-1:0]   r_rem;
    logic [COLS_W-1:0]   r_div;
    logic [COLS_W:0]     trial;
    logic [COLS_W:0]     diff;
    logic                take;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[TILE_W-1]};
    assign take  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[TILE_W-2:0], take};
                r_rem  <= take ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(TILE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

[rtl/sfs_seq.sv]
// ----------------------------------------------------------------------------
// sfs_seq: frame table and draw sequencer
// Holds the frame table memory, frame pointer and delay counter, runs each
// command and forms the tile rectangle in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_seq import sfs_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    sfs_in_if.sink        i_item,
    sfs_out_if.source     o_rect,
    output t_div_req      o_div_req,
    input  wire t_div_rsp i_div_rsp
);

    localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CMP_W  = 11;
    localparam logic [CMP_W-1:0] MAXF = CMP_W'(MAX_FRAMES);
    localparam int LFULL_W = COLS_W + DIM_W;
    localparam int TFULL_W = TILE_W + DIM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_PUT
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_ptr;
    logic [DELAY_W-1:0]  r_cnt;
    logic [TILE_W-1:0]   r_rd_data;
    logic                r_bad;
    logic [LFULL_W-1:0]  r_left_full;
    logic [TFULL_W-1:0]  r_top_full;

    logic                r_out_valid;
    logic [LEFT_W-1:0]   r_out_left;
    logic [TOP_W-1:0]    r_out_top;
    logic [RIGHT_W-1:0]  r_out_right;
    logic [BOTTOM_W-1:0] r_out_bottom;
    logic                r_out_invalid;

    logic [TILE_W-1:0]   mem [MAX_FRAMES];

    logic                accept;
    logic                is_load;
    logic                is_draw;
    logic                is_refresh;
    logic                slot_ok;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DELAY_W:0]    n_cnt_ext;
    logic                adv;
    logic [ADDR_W:0]     n_ptr_ext;
    logic                wrap;
    logic [ADDR_W-1:0]   n_ptr;
    logic [DELAY_W-1:0]  n_cnt;
    logic [COLS_W-1:0]   cols;
    logic                out_free;
    logic [LFULL_W:0]    right_sum;
    logic [TFULL_W:0]    bottom_sum;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign is_load      = accept && (i_item.func == FN_LOAD);
    assign is_draw      = accept && (i_item.func == FN_DRAW);
    assign is_refresh   = accept && (i_item.func == FN_REFRESH);
    assign slot_ok      = CMP_W'(i_item.entry_index) < MAXF;
    assign wr_addr      = ADDR_W'(i_item.entry_index);

    // Frame advance: hold the frame until the counter passes the delay
    assign n_cnt_ext = {1'b0, r_cnt} + 1'b1;
    assign adv       = n_cnt_ext > {1'b0, i_cfg.frame_delay};
    assign n_ptr_ext = {1'b0, r_ptr} + 1'b1;
    assign wrap      = (CMP_W'(n_ptr_ext) >= CMP_W'(i_cfg.frame_count)) ||
                       (CMP_W'(n_ptr_ext) >= MAXF);
    assign n_ptr     = wrap ? '0 : n_ptr_ext[ADDR_W-1:0];
    assign n_cnt     = n_cnt_ext[DELAY_W-1:0];

    assign cols = (i_cfg.sheet_columns == '0) ? COLS_W'(1) : i_cfg.sheet_columns;

    assign o_div_req.start    = (r_state == S_READ);
    assign o_div_req.dividend = r_rd_data - i_cfg.first_tile_id;
    assign o_div_req.divisor  = cols;

    assign out_free   = !r_out_valid || o_rect.ready;
    assign right_sum  = {1'b0, r_left_full} + (LFULL_W + 1)'(i_cfg.tile_width);
    assign bottom_sum = {1'b0, r_top_full} + (TFULL_W + 1)'(i_cfg.tile_height);

    // Frame table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (is_load && slot_ok) begin
            mem[wr_addr] <= i_item.entry_tile_id;
        end
        if (is_draw) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drain the output register; a finished draw refills it instead
            if (r_out_valid && o_rect.ready && (r_state != S_PUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (is_refresh) begin
                        r_ptr <= '0;
                        r_cnt <= '0;
                    end
                    if (is_draw) begin
                        // Pointer read was issued this edge; advance now
                        r_state <= S_READ;
                        if (adv) begin
                            r_cnt <= '0;
                            r_ptr <= n_ptr;
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_READ: begin
                    r_bad   <= r_rd_data < i_cfg.first_tile_id;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_left_full <= LFULL_W'(i_div_rsp.remainder) *
                                       LFULL_W'(i_cfg.tile_width);
                        r_top_full  <= TFULL_W'(i_div_rsp.quotient) *
                                       TFULL_W'(i_cfg.tile_height);
                        r_state     <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_invalid <= r_bad;
                        r_out_left    <= r_bad ? '0 : r_left_full[LEFT_W-1:0];
                        r_out_top     <= r_bad ? '0 : r_top_full[TOP_W-1:0];
                        r_out_right   <= r_bad ? '0 : right_sum[RIGHT_W-1:0];
                        r_out_bottom  <= r_bad ? '0 : bottom_sum[BOTTOM_W-1:0];
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rect.valid       = r_out_valid;
    assign o_rect.rect_left   = r_out_left;
    assign o_rect.rect_top    = r_out_top;
    assign o_rect.rect_right  = r_out_right;
    assign o_rect.rect_bottom = r_out_bottom;
    assign o_rect.invalid     = r_out_invalid;

    a_ptr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_ptr) < MAXF)
        else $error("frame pointer left the table");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_draw_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_draw |=> (r_state == S_READ))
        else $error("draw did not start a table read");

    a_refresh_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_refresh |=> (r_ptr == '0) && (r_cnt == '0))
        else $error("refresh did not clear pointer and counter");

    a_put_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) && out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished draw not placed in the output register");

endmodule

`default_nettype wire

[rtl/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// sprite_frame_sequencer: sprite animation sequencer
// Frame table of tile ids with a frame pointer and delay counter; each draw
// returns the source rectangle of the current frame's tile in the sheet.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Transaction
//  --------  ---------  --------------------  ---------------------------------
//  i_item    in         valid / ready         load entry, draw or refresh
//  o_rect    out        valid / ready         tile rectangle + invalid flag
//  APB       in         psel/penable, pready  register write / read
//
//  Steps: load and refresh take effect at the accepting edge. A draw
//  issues the table read at the accepting edge, then subtracts the first
//  id and starts the divider, runs the bit-serial divider, multiplies the
//  remainder and quotient by tile width and height, and fills the output
//  register. The divider sets the time.
//  Reset: synchronous, active low; clears pointer, counter and registers.
//  The frame table is not cleared; draw only entries that were loaded.
//  Stalls: a finished rectangle waits in the output register while the
//  next transaction is taken; a draw holds in its last step only while
//  the output register is full and not taken.
//
`default_nettype none

module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    sfs_in_if.sink                     i_item,
    sfs_out_if.source                  o_rect,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Register file: geometry and timing; the user must write it only while idle, the block does not enforce this
    sfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Divider: splits the relative tile id into row and column
    sfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Frame table memory, animation state and rectangle output register
    sfs_seq #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_item    (i_item),
        .o_rect    (o_rect),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp)
    );

endmodule

`default_nettype wire

[tb/sv/sprite_frame_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_tb: self-checking bench of the sprite frame sequencer
// Drives load, draw and refresh transactions on the command channel and
// programs the registers over APB between phases. A bit-accurate model of
// the frame table, frame pointer and delay counter predicts each tile
// rectangle. Every rectangle taken from the output channel is compared field
// by field. A directed table comes first, then random traffic under six
// register settings and three idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer_tb;
    import sfs_pkg::*;

    localparam int MAX_FRAMES       = DEF_MAX_FRAMES;
    localparam int NUM_PHASES       = 6;
    localparam int ITEMS_PER_PHASE  = 108;
    localparam int SETTLE_CYCLES    = 30;
    localparam int RX_HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS       = 5_000_000;

    // Function code that the block must ignore
    localparam logic [FUNC_W-1:0]    FN_UNUSED    = 2'd3;
    // Register index beyond the map; a write there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_PAST_END = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] idx;
        logic [TILE_W-1:0]  tile;
    } cmd_t;

    typedef struct packed {
        logic [LEFT_W-1:0]   left;
        logic [TOP_W-1:0]    top;
        logic [RIGHT_W-1:0]  right;
        logic [BOTTOM_W-1:0] bottom;
        logic                invalid;
    } rect_t;

    typedef enum {ROW_CMD, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e              kind;
        cmd_t                   cmd;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [APB_DATA_W-1:0]  value;
        bit                     golden;   // rect below is the known answer
        rect_t                  rect;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    sfs_in_if  in_if ();
    sfs_out_if out_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sprite_frame_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_if),
        .o_rect  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the sequencer: frame table, pointer, delay counter and
    // the register file. Updated in transaction order.
    // ------------------------------------------------------------------------
    t_cfg              cfg;
    logic [TILE_W-1:0] tile_table [MAX_FRAMES];
    bit                tile_loaded [MAX_FRAMES];
    int                frame_ptr;
    int                hold_count;

    rect_t pending_rects [$];      // rectangles owed by the block, oldest first

    int mismatches  = 0;
    int rects_seen  = 0;
    int n_loads     = 0;
    int n_draws     = 0;
    int n_refreshes = 0;
    int n_unused    = 0;

    // Apply one accepted transaction to the shadow state. Return 1 with the
    // tile rectangle when the transaction is a draw.
    function automatic bit sequence_step(input cmd_t c, output rect_t r);
        longint unsigned id, first, rel, cols, left, top;
        int              next_ptr;
        r = '0;
        case (c.func)
            FN_LOAD: begin
                tile_table[c.idx]  = c.tile;
                tile_loaded[c.idx] = 1'b1;
                return 1'b0;
            end
            FN_REFRESH: begin
                frame_ptr  = 0;
                hold_count = 0;
                return 1'b0;
            end
            FN_DRAW: ;
            default: return 1'b0;
        endcase

        id    = tile_table[frame_ptr];
        first = cfg.first_tile_id;
        // zero columns behaves as a single column
        cols  = (cfg.sheet_columns == '0) ? 1 : cfg.sheet_columns;
        if (id < first) begin
            // below the sheet: flag it, all coordinates stay zero
            r.invalid = 1'b1;
        end else begin
            rel      = id - first;
            left     = (rel % cols) * cfg.tile_width;
            top      = (rel / cols) * cfg.tile_height;
            // compute at full width, then wrap each field to its port width
            r.left   = LEFT_W'(left);
            r.top    = TOP_W'(top);
            r.right  = RIGHT_W'(left + cfg.tile_width);
            r.bottom = BOTTOM_W'(top + cfg.tile_height);
        end

        // Hold the frame until the counter passes the delay, then advance
        // and wrap at the frame count (a count of zero pins the pointer).
        if (hold_count + 1 > cfg.frame_delay) begin
            hold_count = 0;
            next_ptr   = frame_ptr + 1;
            if (next_ptr >= cfg.frame_count || next_ptr >= MAX_FRAMES)
                next_ptr = 0;
            frame_ptr = next_ptr;
        end else begin
            hold_count++;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Command channel driver. Idle at random, then hold the transaction until
    // the block takes it. Valid stays high into the next transaction unless
    // the next call idles first.
    // ------------------------------------------------------------------------
    int tx_idle_pct = 35;

    task automatic send_command(input cmd_t c);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.func          <= c.func;
        in_if.entry_index   <= c.idx;
        in_if.entry_tile_id <= c.tile;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        case (c.func)
            FN_LOAD:    n_loads++;
            FN_DRAW:    n_draws++;
            FN_REFRESH: n_refreshes++;
            default:    n_unused++;
        endcase
    endtask

    // Drop valid, wait for every owed rectangle, then let a load or refresh
    // still in flight finish before the registers are touched.
    task automatic await_idle();
        in_if.valid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready, then idle with
    // psel low.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FIRST_TILE_ID: cfg.first_tile_id = value[TILE_W-1:0];
            REG_SHEET_COLUMNS: cfg.sheet_columns = value[COLS_W-1:0];
            REG_TILE_WIDTH:    cfg.tile_width    = value[DIM_W-1:0];
            REG_TILE_HEIGHT:   cfg.tile_height   = value[DIM_W-1:0];
            REG_FRAME_DELAY:   cfg.frame_delay   = value[DELAY_W-1:0];
            REG_FRAME_COUNT:   cfg.frame_count   = value[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Rectangle receiver. Stall at random; on each new hold request keep
    // ready low for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------------
    int rx_idle_pct  = 88;
    int hold_req_id  = 0;
    int hold_seen_id = 0;
    int hold_left    = 0;

    initial out_if.ready = 1'b0;

    always @(posedge i_clk) begin
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id = hold_req_id;
            hold_left    = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Rectangle checker: compare each transaction with the oldest owed one.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        rect_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            rects_seen++;
            if (pending_rects.size() == 0) begin
                $display("%0t ns: rectangle with none owed, expected nothing, actual %0d %0d %0d %0d %0b",
                         $time, out_if.rect_left, out_if.rect_top, out_if.rect_right,
                         out_if.rect_bottom, out_if.invalid);
                mismatches++;
            end else begin
                want = pending_rects.pop_front();
                check_field("rect_left",   want.left,    out_if.rect_left);
                check_field("rect_top",    want.top,     out_if.rect_top);
                check_field("rect_right",  want.right,   out_if.rect_right);
                check_field("rect_bottom", want.bottom,  out_if.rect_bottom);
                check_field("invalid",     want.invalid, out_if.invalid);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [$];

    task automatic add_cmd(input logic [FUNC_W-1:0] func, input int idx, input int tile);
        stim_row_t row;
        row.kind    = ROW_CMD;
        row.cmd     = '{func, INDEX_W'(idx), TILE_W'(tile)};
        row.reg_idx = '0;
        row.value   = '0;
        row.golden  = 1'b0;
        row.rect    = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_draw_known(input int left, input int top, input int right,
                                  input int bottom, input bit bad);
        add_cmd(FN_DRAW, 0, 0);
        directed_rows[$].golden = 1'b1;
        directed_rows[$].rect   = '{LEFT_W'(left), TOP_W'(top), RIGHT_W'(right),
                                    BOTTOM_W'(bottom), bad};
    endtask

    task automatic add_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        add_cmd(FN_LOAD, 0, 0);
        directed_rows[$].kind    = ROW_REG;
        directed_rows[$].reg_idx = idx;
        directed_rows[$].value   = value;
    endtask

    // Register settings of the random phases, extremes and out-of-range
    // geometry among them.
    t_cfg phase_cfg [NUM_PHASES];

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cmd_t  c;
        rect_t r;
        int    n;
        int    roll;
        int    span;
        int    cols;

        in_if.valid         <= 1'b0;
        in_if.func          <= FN_LOAD;
        in_if.entry_index   <= '0;
        in_if.entry_tile_id <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        cfg = '{RST_FIRST_TILE_ID, RST_SHEET_COLUMNS, RST_TILE_WIDTH, RST_TILE_HEIGHT,
                RST_FRAME_DELAY, RST_FRAME_COUNT};
        frame_ptr  = 0;
        hold_count = 0;
        foreach (tile_loaded[i]) tile_loaded[i] = 1'b0;

        phase_cfg[0] = '{16'd100,   9'd8,   9'd16,  9'd16,  8'd0,   7'd8};
        phase_cfg[1] = '{16'd0,     9'd256, 9'd256, 9'd256, 8'd255, 7'd64};
        phase_cfg[2] = '{16'd65535, 9'd1,   9'd1,   9'd1,   8'd1,   7'd1};
        phase_cfg[3] = '{16'd37,    9'd5,   9'd24,  9'd40,  8'd3,   7'd64};
        phase_cfg[4] = '{16'd1000,  9'd13,  9'd200, 9'd100, 8'd2,   7'd20};
        phase_cfg[5] = '{16'd4096,  9'd0,   9'd511, 9'd300, 8'd0,   7'd127};

        // Reset defaults: first id 1, one column, 16x16 tiles, no delay, one frame.
        add_cmd(FN_LOAD, 0, 1);
        add_draw_known(0, 0, 16, 16, 0);                     // first tile of the sheet
        add_cmd(FN_LOAD, 0, 0);
        add_draw_known(0, 0, 0, 0, 1);                       // id below the first id
        add_cmd(FN_LOAD, 0, 65535);
        add_draw_known(0, 1048544, 16, 1048560, 0);          // largest id
        add_cmd(FN_UNUSED, 63, 65535);                       // ignored, no rectangle
        add_cmd(FN_LOAD, 63, 16'h5a5a);
        add_cmd(FN_LOAD, 1, 2);
        add_cmd(FN_REFRESH, 0, 0);
        add_draw_known(0, 1048544, 16, 1048560, 0);
        // frame count of zero pins the pointer on slot 0
        add_reg(REG_FRAME_COUNT, 32'd0);
        add_draw_known(0, 1048544, 16, 1048560, 0);
        add_draw_known(0, 1048544, 16, 1048560, 0);
        // largest top and bottom
        add_reg(REG_FIRST_TILE_ID, 32'd0);
        add_reg(REG_TILE_HEIGHT, 32'd256);
        add_reg(REG_TILE_WIDTH, 32'd256);
        add_draw_known(0, 16776960, 256, 16777216, 0);
        // largest left and right
        add_reg(REG_SHEET_COLUMNS, 32'd256);
        add_draw_known(65280, 65280, 65536, 65536, 0);
        // zero columns counts as one column
        add_reg(REG_SHEET_COLUMNS, 32'd0);
        add_draw_known(0, 16776960, 256, 16777216, 0);
        // write past the register map leaves everything alone
        add_reg(REG_PAST_END, 32'hffff_ffff);
        add_draw_known(0, 16776960, 256, 16777216, 0);
        // two frames, each held for two draws
        add_reg(REG_FRAME_DELAY, 32'd1);
        add_reg(REG_FRAME_COUNT, 32'd2);
        add_cmd(FN_REFRESH, 0, 0);
        repeat (4) add_cmd(FN_DRAW, 0, 0);
        // oversized tiles wrap the left and right coordinates to their field widths
        add_reg(REG_TILE_WIDTH, 32'd511);
        add_reg(REG_TILE_HEIGHT, 32'd511);
        add_reg(REG_SHEET_COLUMNS, 32'd256);
        repeat (2) add_cmd(FN_DRAW, 0, 0);

        // Hold reset, then release it for good.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table. Known answers replace the prediction;
        // the shadow state advances either way.
        tx_idle_pct = 35;
        rx_idle_pct <= 88;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                await_idle();
                write_register(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_command(directed_rows[i].cmd);
                if (sequence_step(directed_rows[i].cmd, r))
                    pending_rects.push_back(directed_rows[i].golden ? directed_rows[i].rect : r);
            end
        end

        // Random phases: sender idles 35% and receiver 88% first, then the
        // other way round, then neither.
        for (int p = 0; p < NUM_PHASES; p++) begin
            await_idle();
            write_register(REG_FIRST_TILE_ID, 32'(phase_cfg[p].first_tile_id));
            write_register(REG_SHEET_COLUMNS, 32'(phase_cfg[p].sheet_columns));
            write_register(REG_TILE_WIDTH,    32'(phase_cfg[p].tile_width));
            write_register(REG_TILE_HEIGHT,   32'(phase_cfg[p].tile_height));
            write_register(REG_FRAME_DELAY,   32'(phase_cfg[p].frame_delay));
            write_register(REG_FRAME_COUNT,   32'(phase_cfg[p].frame_count));

            if (p < 2) begin
                tx_idle_pct = 35;
                rx_idle_pct <= 88;
            end else if (p < 4) begin
                tx_idle_pct = 88;
                rx_idle_pct <= 35;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            // Starve the output for a long stretch while commands keep coming.
            if (p == 4)
                hold_req_id <= hold_req_id + 1;

            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                // Frames the pointer can reach; loads favor those slots.
                span = (cfg.frame_count == '0) ? 1 :
                       (cfg.frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(cfg.frame_count);
                cols = (cfg.sheet_columns == '0) ? 1 : int'(cfg.sheet_columns);
                c.idx = INDEX_W'($urandom_range(63));
                case ($urandom_range(9))
                    0, 1:    c.tile = TILE_W'($urandom);
                    2:       c.tile = cfg.first_tile_id - 16'd1;   // just under the sheet
                    default: c.tile = cfg.first_tile_id + TILE_W'($urandom_range(cols * 6));
                endcase

                roll = $urandom_range(99);
                if (roll < 30) begin
                    c.func = FN_LOAD;
                    if ($urandom_range(3) != 0)
                        c.idx = INDEX_W'($urandom_range(span - 1));
                end else if (roll < 85) begin
                    // Never draw a slot that was never loaded; load it instead.
                    if (tile_loaded[frame_ptr]) begin
                        c.func = FN_DRAW;
                    end else begin
                        c.func = FN_LOAD;
                        c.idx  = INDEX_W'(frame_ptr);
                    end
                end else if (roll < 95) begin
                    c.func = FN_REFRESH;
                end else begin
                    c.func = FN_UNUSED;
                end

                send_command(c);
                if (sequence_step(c, r))
                    pending_rects.push_back(r);

                if (c.func != FN_UNUSED) begin
                    n++;
                    // Pause once mid-phase until the block has drained.
                    if (p == 2 && n == ITEMS_PER_PHASE / 2)
                        await_idle();
                end
            end
        end

        await_idle();

        $display("Covered %0d loads, %0d draws, %0d refreshes, %0d unused codes",
                 n_loads, n_draws, n_refreshes, n_unused);
        $display("over %0d register settings; %0d rectangles checked, %0d mismatches",
                 NUM_PHASES + 1, rects_seen, mismatches);
        if (mismatches == 0)
            $display("sprite_frame_sequencer_tb passed");
        else
            $display("sprite_frame_sequencer_tb failed");
        $finish;
    end

    // Watchdog: a stuck handshake or a missing rectangle ends up here.
    initial begin
        #(TIMEOUT_NS);
        $display("sprite_frame_sequencer_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
